### design/multi_stepper_pulse_generator_unit_macros.svh
// Assertion macros shared by the stepper pulse generator RTL.
// Needs clk_i and rst_ni in the scope that uses the short form.
`ifndef MULTI_STEPPER_PULSE_GENERATOR_UNIT_MACROS_SVH
`define MULTI_STEPPER_PULSE_GENERATOR_UNIT_MACROS_SVH

// Check a property on a given clock, disabled while reset is low.
`define MSP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk_i with rst_ni.
`define MSP_ASSERT(label, prop, msg) \
  `MSP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### design/msp_pkg.sv
// Package of the stepper pulse generator: widths, codes, motor record type.
// No dependencies; used by every module of the block.
package msp_pkg;

  localparam int MotorCountDefault = 4;
  localparam int SpeedW            = 16;
  localparam int IntervalW         = 20;
  localparam int PulseW            = 10;
  localparam int LedW              = 20;
  localparam int CfgIndexW         = 3;
  localparam int CfgDataW          = 20;
  localparam int LineCount         = 4;

  // One second in microsecond ticks, dividend of the interval divide.
  localparam logic [IntervalW-1:0] TicksPerSecond = 20'd1000000;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PULSE_WIDTH  = 3'd0,
    CFG_LED_HOLD     = 3'd1,
    CFG_ENABLE_LEVEL = 3'd2,
    CFG_PULSE_LEVEL  = 3'd3,
    CFG_LED_PRESENT  = 3'd4
  } msp_cfg_idx_e;

  typedef enum logic {
    ACT_TICK      = 1'b0,
    ACT_SET_SPEED = 1'b1
  } msp_action_e;

  // Per-motor state as held in the state memory.
  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic [IntervalW-1:0]     interval;
    logic [IntervalW-1:0]     elapsed;
    logic [PulseW-1:0]        pulse_rem;
    logic                     enabled;
    logic                     forward;
  } msp_rec_t;

  localparam msp_rec_t RecReset = '{
    speed:     '0,
    interval:  '0,
    elapsed:   '0,
    pulse_rem: '0,
    enabled:   1'b1,
    forward:   1'b1
  };

  // Interval raised above the pulse width.
  function automatic logic [IntervalW-1:0] clamp_interval(
    input logic [IntervalW-1:0] iv,
    input logic [PulseW-1:0]    pw
  );
    logic [IntervalW-1:0] pw_ext;
    pw_ext = IntervalW'(pw);
    if (iv <= pw_ext) begin
      clamp_interval = pw_ext + IntervalW'(1);
    end else begin
      clamp_interval = iv;
    end
  endfunction

endpackage

### design/msp_state_mem.sv
// Per-motor state memory: one write port, one registered read port.
// Valid bits make never-written entries read as the reset record. Uses msp_pkg.
module msp_state_mem #(
  parameter int Depth = msp_pkg::MotorCountDefault,
  parameter int AddrW = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output msp_pkg::msp_rec_t rdata_o,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  msp_pkg::msp_rec_t wdata_i
);
  import msp_pkg::*;

  msp_rec_t             ram_q [Depth];
  logic [Depth-1:0]     valid_q;
  msp_rec_t             rdata_q;
  logic                 rvalid_q;

  // Write and read the array.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= ram_q[raddr_i];
    end
  end

  // Track written entries; hold the read entry's valid bit with its data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : RecReset;

endmodule

### design/msp_divider.sv
// Serial restoring divider: one second in ticks over a 16-bit magnitude.
// One quotient bit per cycle, done pulses one cycle. Uses msp_pkg.
module msp_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msp_pkg::SpeedW-1:0]    divisor_i,
  output logic [msp_pkg::IntervalW-1:0] quotient_o,
  output logic                          done_o
);
  import msp_pkg::*;

  localparam int Steps = IntervalW;
  localparam int CntW  = $clog2(Steps);

  logic [SpeedW-1:0]    div_q;
  logic [SpeedW-1:0]    rem_q, rem_d;
  logic [IntervalW-1:0] quo_q, quo_d;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [SpeedW:0]      trial;
  logic [SpeedW:0]      diff;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem_q, quo_q[IntervalW-1]};
    diff  = trial - {1'b0, div_q};
    if (trial >= {1'b0, div_q}) begin
      rem_d = diff[SpeedW-1:0];
      quo_d = {quo_q[IntervalW-2:0], 1'b1};
    end else begin
      rem_d = trial[SpeedW-1:0];
      quo_d = {quo_q[IntervalW-2:0], 1'b0};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= TicksPerSecond;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Step counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      // Pulse done on the cycle after the last step.
      done_q <= !start_i && busy_q && (cnt_q == CntW'(Steps - 1));
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

### design/msp_motor_alu.sv
// Tick update of one motor record: pulse countdown, enable, direction, step.
// Combinational; uses msp_pkg.
module msp_motor_alu (
  input  msp_pkg::msp_rec_t           rec_i,
  input  logic [msp_pkg::PulseW-1:0]  pulse_width_i,
  output msp_pkg::msp_rec_t           rec_o,
  output logic                        stepped_o
);
  import msp_pkg::*;

  logic                 fwd;
  logic [IntervalW-1:0] el_inc;

  always_comb begin
    rec_o     = rec_i;
    stepped_o = 1'b0;
    fwd       = ~rec_i.speed[SpeedW-1];
    el_inc    = (rec_i.elapsed == '1) ? rec_i.elapsed : rec_i.elapsed + IntervalW'(1);
    if (rec_i.pulse_rem != '0) begin
      // Count the pulse down; restart the interval at its end.
      rec_o.pulse_rem = rec_i.pulse_rem - PulseW'(1);
      if (rec_i.pulse_rem == PulseW'(1)) begin
        rec_o.elapsed = '0;
      end
    end else begin
      rec_o.elapsed = el_inc;
      if (rec_i.speed == '0) begin
        rec_o.enabled = 1'b0;
      end else begin
        rec_o.enabled = 1'b1;
        // Flip direction and restart the interval on a sign change.
        if (rec_i.forward != fwd) begin
          rec_o.forward = fwd;
          rec_o.elapsed = '0;
        end
        if (rec_o.elapsed >= clamp_interval(rec_i.interval, pulse_width_i)) begin
          rec_o.pulse_rem = pulse_width_i;
          if (pulse_width_i == '0) begin
            rec_o.elapsed = '0;
          end
          stepped_o = 1'b1;
        end
      end
    end
  end

endmodule

### design/multi_stepper_pulse_generator_unit.sv
// Top level of the stepper step/direction/enable pulse generator.
// Uses msp_pkg, msp_state_mem, msp_divider, msp_motor_alu and the macros header.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-------------------------------------
//  s_axis    | in        | tvalid/tready        | tuser: action; tdata: index, speed
//  m_axis    | out       | tvalid/tready        | tdata: enable, direction, pulse, led
//  cfg       | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A tick item does one state memory read-modify-write per motor.
// A set-speed item waits for the 20-step serial divider.
// Reset needs no clearing pass: per-entry valid bits return the reset record.
// The result register frees the input side; a new item is taken while a result waits,
// and the block holds its next result until the previous one is taken.
module multi_stepper_pulse_generator_unit #(
  parameter int MotorCount = msp_pkg::MotorCountDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // motor_index[1:0], speed_value[17:2]
  input  logic                           s_axis_tuser,  // action[0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // enable[3:0], direction[7:4],
                                                        // pulse[11:8], led[12]
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [msp_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [msp_pkg::CfgDataW-1:0]   cfg_data_i
);
  import msp_pkg::*;

`include "multi_stepper_pulse_generator_unit_macros.svh"

  localparam int AddrW    = (MotorCount > 1) ? $clog2(MotorCount) : 1;
  localparam int LineW    = (MotorCount < LineCount) ? MotorCount : LineCount;
  localparam logic [LineCount-1:0] LineMask = LineCount'((1 << LineW) - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TICK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } msp_state_e;

  msp_state_e state_q, state_d;

  // Configuration registers.
  logic [PulseW-1:0] pw_q;
  logic [LedW-1:0]   led_hold_q;
  logic              en_lvl_q;
  logic              pls_lvl_q;
  logic              led_present_q;

  // Item and sequencing registers.
  logic [1:0]              idx_q;
  logic signed [SpeedW-1:0] spd_q;
  logic [AddrW-1:0]        cur_q;
  logic                    stepped_q;
  logic [LedW-1:0]         led_rem_q;
  logic                    led_on_q;
  logic [LineW-1:0]        en_img_q, fwd_img_q, pls_img_q;
  logic                    m_valid_q;
  logic [15:0]             m_data_q;

  // Memory, divider and update unit connections.
  logic             mem_re, mem_we;
  logic [AddrW-1:0] mem_raddr, mem_waddr;
  msp_rec_t         mem_rdata, mem_wdata;
  msp_rec_t         alu_rec;
  logic             alu_stepped;
  logic             div_start, div_done;
  logic [IntervalW-1:0] div_quo;

  logic                 s_accept;
  logic                 is_tick;
  logic [1:0]           in_idx;
  logic signed [SpeedW-1:0] in_spd;
  logic [SpeedW-1:0]    in_mag;
  logic                 idx_ok;
  logic                 last_motor;
  logic                 out_load;
  logic [IntervalW-1:0] set_interval;
  msp_rec_t             set_rec;
  logic [LineCount-1:0] en_line, fwd_line, pls_line;
  logic                 led_line;
  logic                 stepped_all;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (msp_action_e'(s_axis_tuser) == ACT_TICK);
  assign in_idx        = s_axis_tdata[1:0];
  assign in_spd        = s_axis_tdata[17:2];
  assign in_mag        = in_spd[SpeedW-1] ? (~in_spd + SpeedW'(1)) : in_spd;
  assign idx_ok        = (int'(idx_q) < MotorCount);
  assign last_motor    = (cur_q == AddrW'(MotorCount - 1));
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  assign stepped_all   = stepped_q || alu_stepped;
  assign cfg_ready_o   = 1'b1;

  msp_state_mem #(
    .Depth (MotorCount),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  msp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (in_mag),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  msp_motor_alu u_alu (
    .rec_i         (mem_rdata),
    .pulse_width_i (pw_q),
    .rec_o         (alu_rec),
    .stepped_o     (alu_stepped)
  );

  // Merge a new speed and interval into the stored record.
  always_comb begin
    set_interval = (spd_q == '0) ? '0 : clamp_interval(div_quo, pw_q);
    set_rec          = mem_rdata;
    set_rec.speed    = spd_q;
    set_rec.interval = set_interval;
  end

  // Sequence memory reads, writes and the divider.
  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_raddr = cur_q + AddrW'(1);
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = alu_rec;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          mem_re = 1'b1;
          if (is_tick) begin
            mem_raddr = '0;
            state_d   = ST_TICK;
          end else begin
            mem_raddr = AddrW'(in_idx);
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_TICK: begin
        mem_we = 1'b1;
        if (last_motor) begin
          state_d = ST_DONE;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mem_we    = idx_ok;
          mem_waddr = AddrW'(idx_q);
          mem_wdata = set_rec;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Build the line levels from the images and the configured polarities.
  always_comb begin
    en_line  = ~(LineCount'(en_img_q) ^ {LineCount{en_lvl_q}}) & LineMask;
    fwd_line = LineCount'(fwd_img_q);
    pls_line = ~(LineCount'(pls_img_q) ^ {LineCount{pls_lvl_q}}) & LineMask;
    led_line = led_on_q & led_present_q;
  end

  // Hold the item fields of an accepted item and load the result data word.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      idx_q <= in_idx;
      spd_q <= in_spd;
    end
    if (out_load) begin
      m_data_q <= {3'b000, led_line, pls_line, fwd_line, en_line};
    end
  end

  // Control state, configuration, line images, the LED and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pw_q          <= PulseW'(10);
      led_hold_q    <= LedW'(50000);
      en_lvl_q      <= 1'b0;
      pls_lvl_q     <= 1'b1;
      led_present_q <= 1'b1;
      cur_q         <= '0;
      stepped_q     <= 1'b0;
      led_rem_q     <= '0;
      led_on_q      <= 1'b0;
      en_img_q      <= '1;
      fwd_img_q     <= '1;
      pls_img_q     <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      // Take configuration writes.
      if (cfg_valid_i) begin
        case (msp_cfg_idx_e'(cfg_index_i))
          CFG_PULSE_WIDTH:  pw_q          <= cfg_data_i[PulseW-1:0];
          CFG_LED_HOLD:     led_hold_q    <= cfg_data_i[LedW-1:0];
          CFG_ENABLE_LEVEL: en_lvl_q      <= cfg_data_i[0];
          CFG_PULSE_LEVEL:  pls_lvl_q     <= cfg_data_i[0];
          CFG_LED_PRESENT:  led_present_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end

      // Start a tick sweep at motor zero.
      if (s_accept && is_tick) begin
        cur_q     <= '0;
        stepped_q <= 1'b0;
      end

      // Advance the sweep, mirror the written motor into the line images.
      if (state_q == ST_TICK) begin
        cur_q     <= cur_q + AddrW'(1);
        stepped_q <= stepped_all;
        for (int j = 0; j < LineW; j++) begin
          if (cur_q == AddrW'(j)) begin
            en_img_q[j]  <= alu_rec.enabled;
            fwd_img_q[j] <= alu_rec.forward;
            pls_img_q[j] <= (alu_rec.pulse_rem != '0);
          end
        end
        // Update the activity LED after the last motor.
        if (last_motor) begin
          if (led_present_q) begin
            if (stepped_all) begin
              led_rem_q <= led_hold_q;
              led_on_q  <= 1'b1;
            end else if (led_on_q) begin
              if (led_rem_q == '0) begin
                led_on_q <= 1'b0;
              end else begin
                led_rem_q <= led_rem_q - LedW'(1);
              end
            end
          end else begin
            led_on_q <= 1'b0;
          end
        end
      end

      // Load or drop the result register.
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `MSP_ASSERT(a_mem_no_same_entry, !(mem_we && mem_re && (mem_waddr == mem_raddr)), "state memory read and write hit one entry")
  `MSP_ASSERT(a_div_done_in_div, div_done |-> (state_q == ST_DIV), "divider finished outside the divide state")
  `MSP_ASSERT(a_sweep_in_range, (state_q == ST_TICK) |-> (int'(cur_q) < MotorCount), "tick sweep past the last motor")
  `MSP_ASSERT(a_result_from_done, $rose(m_valid_q) |-> ($past(state_q) == ST_DONE), "result loaded outside the done state")

endmodule

### bench/multi_stepper_pulse_generator_unit_test.sv
// Self-checking bench for the four-motor step/direction/enable pulse generator.
// Predicts every line word from its own motor state and compares it with the output.
// Depends on msp_pkg and multi_stepper_pulse_generator_unit.

// Tracks motor and LED state and holds the line words still due from the block.
class motor_line_tracker;
  msp_pkg::msp_rec_t motors[4];
  logic [9:0]        pulse_width;
  logic [19:0]       led_hold;
  logic              enable_level;
  logic              pulse_level;
  logic              led_fitted;
  logic [19:0]       led_left;
  logic              led_lit;
  logic [15:0]       line_words_due[$];
  int                mismatches;
  int                words_checked;
  int                steps_seen;

  function new();
    pulse_width   = 10'd10;
    led_hold      = 20'd50000;
    enable_level  = 1'b0;
    pulse_level   = 1'b1;
    led_fitted    = 1'b1;
    led_left      = '0;
    led_lit       = 1'b0;
    mismatches    = 0;
    words_checked = 0;
    steps_seen    = 0;
    foreach (motors[i]) begin
      motors[i] = '{speed: '0, interval: '0, elapsed: '0, pulse_rem: '0,
                    enabled: 1'b1, forward: 1'b1};
    end
  endfunction

  function void apply_register(msp_pkg::msp_cfg_idx_e idx, logic [19:0] data);
    case (idx)
      msp_pkg::CFG_PULSE_WIDTH:  pulse_width  = data[9:0];
      msp_pkg::CFG_LED_HOLD:     led_hold     = data;
      msp_pkg::CFG_ENABLE_LEVEL: enable_level = data[0];
      msp_pkg::CFG_PULSE_LEVEL:  pulse_level  = data[0];
      msp_pkg::CFG_LED_PRESENT:  led_fitted   = data[0];
      default: ;
    endcase
  endfunction

  // Keep the interval above the current pulse width.
  function logic [19:0] raised_interval(logic [19:0] iv);
    if (iv <= {10'd0, pulse_width}) begin
      return {10'd0, pulse_width} + 20'd1;
    end
    return iv;
  endfunction

  function void note_item(msp_pkg::msp_action_e act, logic [1:0] idx,
                          logic signed [15:0] speed);
    int          mag;
    bit          stepped;
    logic        fwd;
    logic [15:0] word;
    stepped = 1'b0;
    if (act == msp_pkg::ACT_SET_SPEED) begin
      // Store speed and interval only; lines move on later ticks.
      mag = (speed < 0) ? -int'(speed) : int'(speed);
      motors[idx].speed    = speed;
      motors[idx].interval = (mag == 0) ? 20'd0 : raised_interval(20'(1000000 / mag));
    end else begin
      // Advance every motor by one microsecond.
      foreach (motors[i]) begin
        if (motors[i].pulse_rem != 0) begin
          motors[i].pulse_rem = motors[i].pulse_rem - 10'd1;
          if (motors[i].pulse_rem == 0) motors[i].elapsed = '0;
          continue;
        end
        if (motors[i].elapsed != 20'hFFFFF) motors[i].elapsed = motors[i].elapsed + 20'd1;
        if (motors[i].speed == 0) begin
          motors[i].enabled = 1'b0;
          continue;
        end
        motors[i].enabled = 1'b1;
        fwd = ($signed(motors[i].speed) > 0);
        if (motors[i].forward != fwd) begin
          motors[i].forward = fwd;
          motors[i].elapsed = '0;
        end
        if (motors[i].elapsed >= raised_interval(motors[i].interval)) begin
          motors[i].pulse_rem = pulse_width;
          if (pulse_width == 0) motors[i].elapsed = '0;
          stepped = 1'b1;
        end
      end
      if (stepped) steps_seen++;
      // Hold the LED after a step, count down otherwise.
      if (led_fitted) begin
        if (stepped) begin
          led_left = led_hold;
          led_lit  = 1'b1;
        end else if (led_lit) begin
          if (led_left == 0) led_lit = 1'b0;
          else led_left = led_left - 20'd1;
        end
      end else begin
        led_lit = 1'b0;
      end
    end
    // Build the expected line word.
    word = '0;
    foreach (motors[i]) begin
      word[i]     = motors[i].enabled ? enable_level : ~enable_level;
      word[4 + i] = motors[i].forward;
      word[8 + i] = (motors[i].pulse_rem != 0) ? pulse_level : ~pulse_level;
    end
    word[12] = led_lit & led_fitted;
    line_words_due = {line_words_due, word};
  endfunction

  function void compare_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endfunction

  function void check_lines(logic [15:0] word);
    logic [15:0] want;
    if (line_words_due.size() == 0) begin
      mismatches++;
      $error("line word %h arrived with none outstanding", word);
      return;
    end
    want = line_words_due.pop_front();
    words_checked++;
    compare_field("enable_lines", want[3:0], word[3:0]);
    compare_field("direction_lines", want[7:4], word[7:4]);
    compare_field("pulse_lines", want[11:8], word[11:8]);
    compare_field("led_line", {3'b0, want[12]}, {3'b0, word[12]});
    compare_field("tdata padding", {1'b0, want[15:13]}, {1'b0, word[15:13]});
  endfunction
endclass

module multi_stepper_pulse_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import msp_pkg::*;

  localparam int Motors = 4;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  motor_line_tracker tracker = new();
  bit  steady;
  int  stall_left;
  int  items_sent;
  int  speeds_set;
  int  settings_used;

  multi_stepper_pulse_generator_unit #(
    .MotorCount(Motors)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Short gaps mostly, an occasional long one, none while steady.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [15:0] pick_speed();
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0001;
        default: return 16'hFFFF;
      endcase
    end
    if (r < 22) return 16'h0000;
    if (r < 65) begin
      mag = $urandom_range(3000, 32767);
      return $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Stall the result side at random.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    = stall_left - 1;
      m_axis_tready = 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      stall_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Check each accepted line word.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_lines(m_axis_tdata);
  end

  // Drive one item from a falling edge and return on the falling edge after acceptance.
  task automatic send_item(msp_action_e act, logic [1:0] idx, logic [15:0] speed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {6'b0, speed, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_item(act, idx, speed);
    items_sent++;
    if (act == ACT_SET_SPEED) speeds_set++;
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
  endtask

  // Drop valid and wait until every line word has come back.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (tracker.line_words_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(msp_cfg_idx_e idx, logic [19:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.apply_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Reconfigure while idle, then run random items.
  task automatic run_phase(logic [9:0] width, logic [19:0] hold, logic en_lvl,
                           logic pl_lvl, logic led, int count);
    wait_drained();
    write_register(CFG_PULSE_WIDTH, {10'd0, width});
    write_register(CFG_LED_HOLD, hold);
    write_register(CFG_ENABLE_LEVEL, {19'd0, en_lvl});
    write_register(CFG_PULSE_LEVEL, {19'd0, pl_lvl});
    write_register(CFG_LED_PRESENT, {19'd0, led});
    settings_used++;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 12) begin
        send_item(ACT_SET_SPEED, 2'($urandom_range(0, 3)), pick_speed());
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: default settings, speed extremes, zero speed, sign flips.
    steady = 1'b0;
    send_tick();
    send_item(ACT_SET_SPEED, 2'd0, 16'h7FFF);
    send_item(ACT_SET_SPEED, 2'd1, 16'h8000);
    send_item(ACT_SET_SPEED, 2'd2, 16'h0001);
    send_item(ACT_SET_SPEED, 2'd3, 16'hFFFF);
    repeat (14) send_tick();
    send_item(ACT_SET_SPEED, 2'd2, 16'h0000);
    send_item(ACT_SET_SPEED, 2'd3, 16'h5555);
    send_item(ACT_SET_SPEED, 2'd1, 16'h2AAA);
    repeat (3) send_tick();

    // Extremes of each register, zero pulse width, LED absent, then random settings.
    run_phase(10'd1, 20'd0, 1'b1, 1'b0, 1'b1, 160);
    run_phase(10'd1000, 20'd1000000, 1'b0, 1'b1, 1'b1, 160);
    run_phase(10'd0, 20'd5, 1'b1, 1'b1, 1'b1, 160);
    run_phase(10'd3, 20'd20, 1'b0, 1'b0, 1'b0, 160);
    for (int p = 0; p < 4; p++) begin
      run_phase(10'($urandom_range(1, 40)), 20'($urandom_range(0, 300)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 4) != 0), 165);
    end

    // Drain, then watch for stray results.
    wait_drained();
    repeat (40) @(negedge clk_i);
    $display("Sent %0d items (%0d speed settings) over %0d register settings;",
             items_sent, speeds_set, settings_used + 1);
    $display("checked %0d line words, %0d ticks produced steps.",
             tracker.words_checked, tracker.steps_seen);
    if (tracker.mismatches == 0 && tracker.line_words_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
